[src/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    ST_GATHER,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [5:0]  PAD_LIMIT = 6'd56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[src/sha256_stream_hasher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Streaming SHA-256 over a byte stream, block bytes held in a 16x32 memory.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: one request per byte (in_message_byte, in_has_byte);
//   in_is_last closes the message, a request with in_has_byte low and
//   in_is_last high closes an empty message or one already sent.
//   output channel: eight digest words, word 0 first, out_last_word on word 7.
// Flow:
//   bytes are taken while the hasher gathers; every 64th byte adds a
//   compression (load, 64 rounds at one round per cycle, update) during
//   which no new request is taken.
//   closing writes padding one byte per cycle up to the end of the block,
//   64 more when the length needs an extra block, with a compression
//   after each padding block, then the eight digest words go out.
// The message schedule runs as a 16-word window loaded from the block
// memory, one memory read per round during the first sixteen rounds.
// Reset returns the chaining words, fill count and length to the start
// state; the block memory is not cleared. While out_stall is high the
// current word is held; no new request is taken until the last word is out.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // block memory: 16 big-endian words, byte-lane writes
  logic [31:0] mem [16];
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_wbe;
  logic        mem_we;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_wbe[b]) mem[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
      end
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  sha_state_t  state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [6:0]  rnd_r;
  logic [5:0]  fill_r;
  logic [60:0] len_r;
  logic        closing_r;   // message is closed, padding path
  logic        final_r;     // padding block carries the length
  logic        mark_r;      // marker byte still to be written
  logic [5:0]  pad_r;       // byte position during padding writes
  logic [2:0]  oidx_r;

  logic        in_acc;
  assign in_stall = (state_r != ST_GATHER);
  assign in_acc   = in_valid && !in_stall;

  logic [31:0] wnew;
  logic [31:0] w_cur;
  logic [31:0] t1, t2;
  always_comb begin
    wnew = w_r[0] + (ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3))
         + w_r[9] + (ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10));
    w_cur = (rnd_r < 7'd16) ? mem_rdata_r : wnew;
    t1 = v_r[7] + (ror32(v_r[4], 6) ^ ror32(v_r[4], 11) ^ ror32(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[rnd_r[5:0]] + w_cur;
    t2 = (ror32(v_r[0], 2) ^ ror32(v_r[0], 13) ^ ror32(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // padding byte at position pad_r: marker first, then zeros and length
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  assign bits = {len_r, 3'b000};
  always_comb begin
    if (mark_r)                             pad_byte = PAD_BYTE;
    else if (pad_r >= PAD_LIMIT && final_r) pad_byte = bits[8*(63 - pad_r) +: 8];
    else                                    pad_byte = 8'h00;
  end

  // marker position after the closing request's byte
  logic [5:0] pad_start;
  assign pad_start = in_has_byte ? fill_r + 6'd1 : fill_r;

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = fill_r[5:2];
    mem_wbe   = 4'b1000 >> fill_r[1:0];
    mem_wdata = {4{in_message_byte}};
    mem_raddr = 4'd0;
    unique case (state_r)
      ST_GATHER: begin
        if (in_acc) begin
          mem_we = in_has_byte;
          if (in_has_byte && fill_r == 6'd63) state_nxt = ST_LOAD;
          else if (in_is_last)               state_nxt = ST_PAD;
        end
      end
      ST_LOAD: begin
        mem_raddr = 4'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        mem_raddr = rnd_r[3:0] + 4'd1;
        if (rnd_r == 7'd63) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (final_r)        state_nxt = ST_EMIT;
        else if (closing_r) state_nxt = ST_PAD;
        else                state_nxt = ST_GATHER;
      end
      ST_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = pad_r[5:2];
        mem_wbe   = 4'b1000 >> pad_r[1:0];
        mem_wdata = {4{pad_byte}};
        if (pad_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_EMIT: begin
        if (!out_stall && oidx_r == 3'd7) state_nxt = ST_GATHER;
      end
      default: state_nxt = ST_GATHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_GATHER;
      fill_r    <= '0;
      len_r     <= '0;
      closing_r <= 1'b0;
      final_r   <= 1'b0;
      mark_r    <= 1'b0;
      pad_r     <= '0;
      oidx_r    <= '0;
      rnd_r     <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_GATHER: begin
          if (in_acc) begin
            if (in_has_byte) begin
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 61'd1;
            end
            if (in_is_last) begin
              closing_r <= 1'b1;
              mark_r    <= 1'b1;
              // a close that arrives with the 64th byte pads a fresh block
              if (in_has_byte && fill_r == 6'd63) begin
                pad_r   <= '0;
                final_r <= 1'b0;
              end else begin
                pad_r   <= pad_start;
                final_r <= (pad_start < PAD_LIMIT);
              end
            end
          end
        end
        ST_LOAD: begin
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= w_cur;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          oidx_r <= '0;
          // the block after a closed non-final one carries the length
          if (closing_r && !final_r) final_r <= 1'b1;
        end
        ST_PAD: begin
          pad_r  <= pad_r + 6'd1;
          mark_r <= 1'b0;
          if (pad_r == 6'd63) fill_r <= '0;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
              fill_r    <= '0;
              len_r     <= '0;
              closing_r <= 1'b0;
              final_r   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  property p_no_take_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_GATHER) |-> in_stall;
  endproperty
  a_no_take_busy: assert property (p_no_take_busy) else $error("request taken while busy");

  property p_emit_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_stall) |=> (out_valid && $stable(out_word_index));
  endproperty
  a_emit_hold: assert property (p_emit_hold) else $error("digest word dropped");

  property p_round_range;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_ROUND) |-> (rnd_r < 7'd64);
  endproperty
  a_round_range: assert property (p_round_range) else $error("round count out of range");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream SHA-256 hasher check: messages of random and edge lengths go
// in with random gaps and output stalls; a scoreboard hashes the same bytes
// and compares every digest word, index and last flag in order.
// ----------------------------------------------------------------------------
module tb
  import sha_pkg::*;
();

  class digest_board;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] byte_count;
    logic [31:0] words_q [$];
    int          errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = INIT_H[i];
      fill = 0;
      byte_count = '0;
    endfunction

    function logic [31:0] rot(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, a, e;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
             + w[i-7] + (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
      v = chain;
      for (int i = 0; i < 64; i++) begin
        a = v[0];
        e = v[4];
        t1 = v[7] + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
           + ROUND_K[i] + w[i];
        t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // note one accepted request
    function void note_request(logic [7:0] b, logic hb, logic last);
      logic [63:0] bits;
      if (hb) begin
        blk[fill] = b;
        fill++;
        byte_count++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!last) return;
      bits = {byte_count, 3'b000};
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > PAD_LIMIT) begin
        for (int i = fill; i < 64; i++) blk[i] = 8'h00;
        compress();
        fill = 0;
      end
      for (int i = fill; i < PAD_LIMIT; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) words_q.push_back(chain[i]);
      restart();
    endfunction

    task check_word(logic [31:0] d, logic [2:0] idx, logic lw);
      logic [31:0] exp_w;
      int          pos;
      if (words_q.size() == 0) begin
        report("digest word with none expected");
        return;
      end
      pos = (8 - (words_q.size() % 8)) % 8;
      exp_w = words_q.pop_front();
      if (d !== exp_w) report($sformatf("word %0d: got %h want %h", pos, d, exp_w));
      if (idx !== 3'(pos)) report($sformatf("index: got %0d want %0d", idx, pos));
      if (lw !== (pos == 7)) report($sformatf("last flag wrong at word %0d", pos));
    endtask

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_message_byte = 0;
  logic        in_has_byte = 0;
  logic        in_is_last = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_board board = new();
  bit          stim_done = 0;
  bit          calm = 0;

  sha256_stream_hasher_top u_top (.*);

  initial forever #5 clk = ~clk;

  task automatic send(logic [7:0] b, logic hb, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_message_byte <= b;
    in_has_byte     <= hb;
    in_is_last      <= last;
    in_valid        <= 1;
    do @(posedge clk); while (in_stall);
    board.note_request(b, hb, last);
    @(negedge clk);
  endtask

  // message of n bytes with random empty requests mixed in, last byte optionally on the close
  task automatic send_message(int n, bit byte_on_close);
    for (int i = 0; i < n - (byte_on_close ? 1 : 0); i++) begin
      if ($urandom_range(0, 9) == 0) send(8'($urandom), 0, 0);
      send(8'($urandom), 1, 0);
    end
    if (byte_on_close && n > 0) send(8'($urandom), 1, 1);
    else send(8'($urandom), 0, 1);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1;
    // directed: empty message, extremes of the byte, padding boundaries
    send(8'h00, 0, 1);
    send(8'hff, 0, 0);
    send(8'hff, 1, 1);
    send(8'h00, 1, 1);
    send(8'h61, 1, 0);
    send(8'h62, 1, 0);
    send(8'h63, 1, 1);
    calm = 1;
    send_message(56, 1);
    calm = 0;
    send_message(64, 1);
    // random short messages
    for (int m = 0; m < 6; m++) begin
      calm = (m % 3 == 2);
      send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
    end
    calm = 0;
    in_valid <= 0;
    stim_done = 1;
  end

  // output side: a drawn number of stall cycles before each result
  initial begin
    int hold;
    forever begin
      hold = $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_digest_word, out_word_index, out_last_word);
  end

  initial begin
    wait (stim_done);
    wait (board.words_q.size() == 0);
    repeat (300) @(posedge clk);
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

[sim.f]
src/sha_pkg.sv
src/sha256_stream_hasher_top.sv
test/tb.sv
